>>> hdl/mvt_pkg.sv
// ---------------------------------------------------------------------------
// mvt_pkg
// Types and constants shared by the matrix vertex transform block.
// ---------------------------------------------------------------------------
`default_nettype none

package mvt_pkg;

	localparam int DATA_W = 32;
	localparam int PROD_W = 2 * DATA_W;
	localparam int ACC_W  = PROD_W + 2;
	localparam int IDX_W  = 4;

	localparam logic [2:0] OP_WR_COEF   = 3'd0;
	localparam logic [2:0] OP_IDENTITY  = 3'd1;
	localparam logic [2:0] OP_ZERO      = 3'd2;
	localparam logic [2:0] OP_CONCAT    = 3'd3;
	localparam logic [2:0] OP_XFORM_PT  = 3'd4;
	localparam logic [2:0] OP_XFORM_DIR = 3'd5;

	localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [2:0]               op;
		logic [3:0]               coef_index;
		logic signed [DATA_W-1:0] coef_value;
		logic signed [DATA_W-1:0] in_x;
		logic signed [DATA_W-1:0] in_y;
		logic signed [DATA_W-1:0] in_z;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] out_x;
		logic signed [DATA_W-1:0] out_y;
		logic signed [DATA_W-1:0] out_z;
		logic                     clipped;
	} result_t;

	// one product term entering the multiply-accumulate pipe
	typedef struct packed {
		logic             valid;
		logic             first;
		logic             last;
		logic [IDX_W-1:0] dest;
	} term_t;

	// one finished dot product
	typedef struct packed {
		logic              valid;
		logic [IDX_W-1:0]  dest;
		logic [DATA_W-1:0] value;
		logic              sat;
	} dot_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_DELIVER
	} state_t;

endpackage

`default_nettype wire

>>> hdl/mvt_ram.sv
// ---------------------------------------------------------------------------
// mvt_ram
// Generic single-write, single-read synchronous RAM, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module mvt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> hdl/mvt_mac.sv
// ---------------------------------------------------------------------------
// mvt_mac
// Shared multiply-accumulate pipe: one 32x32 product per cycle, exact
// four-term sum, round half up, saturate to 32 bits.
// ---------------------------------------------------------------------------
`default_nettype none

module mvt_mac
	import mvt_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire term_t                    term,
	input  wire logic signed [DATA_W-1:0] a,
	input  wire logic signed [DATA_W-1:0] b,
	output dot_t                          dot,
	output logic                          busy
);

	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

	term_t                    ctl_s2;
	term_t                    ctl_s3;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_s3;
	logic signed [ACC_W-1:0]  acc_base;
	logic signed [ACC_W-1:0]  shifted;
	logic [ACC_W-DATA_W:0]    upper;
	logic                     fits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s2 <= term;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a * b;
		if (ctl_s2.valid) begin
			acc_s3 <= acc_base + ACC_W'(prod_s2);
		end
	end

	assign acc_base = ctl_s2.first ? HALF : acc_s3;
	assign shifted  = acc_s3 >>> FRAC_BITS;
	assign upper    = shifted[ACC_W-1:DATA_W-1];
	assign fits     = (&upper) | ~(|upper);

	always_comb begin
		dot.valid = ctl_s3.valid && ctl_s3.last;
		dot.dest  = ctl_s3.dest;
		dot.sat   = !fits;
		if (fits) begin
			dot.value = shifted[DATA_W-1:0];
		end else if (shifted[ACC_W-1]) begin
			dot.value = SAT_MIN;
		end else begin
			dot.value = SAT_MAX;
		end
	end

	assign busy = ctl_s2.valid || ctl_s3.valid;

endmodule

`default_nettype wire

>>> hdl/matrix_vertex_transform.sv
// ---------------------------------------------------------------------------
// matrix_vertex_transform
// 4x4 Q16.16 matrix unit: operand load, identity, zero, concatenate, and
// point / direction transform through the current matrix.
// ---------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  item    | in  | item_valid/item_stall  | item_t   (op, coef, vector)
//  result  | out | result_valid/result_stall | result_t (x, y, z, clipped)
//
//  Coefficient write, identity, zero and unused ops leave the item channel free.
//  Transform and concatenate stall items through issue, drain and (transform only) deliver.
//  One product per cycle from the shared multiplier, 4 per output element.
//  Current matrix is double-banked in one RAM; concatenate writes the idle bank.
//  Reset needs no clearing pass: bank flags and operand valid bits give
//  reset values. A waiting result only holds off the next transform's delivery.
// ---------------------------------------------------------------------------
`default_nettype none

module matrix_vertex_transform
	import mvt_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_stall,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result
);

	localparam logic [DATA_W-1:0] ONE = DATA_W'(64'd1 << FRAC_BITS);

	state_t state_q, state_d;

	logic                    in_xfer;
	logic                    issue;
	logic                    last_issue;
	logic                    load_out;
	logic                    flip;
	logic [5:0]              cnt_q;
	logic                    concat_q;
	logic                    point_q;
	logic [DATA_W-1:0]       vec_q [3];
	logic                    bank_q;
	logic [1:0]              full_q;
	logic                    base_id_q;
	logic [15:0]             opv_q;
	logic [DATA_W-1:0]       res_q [3];
	logic                    clip_q;
	result_t                 out_q;
	logic                    out_valid_q;

	logic [IDX_W-1:0]        cur_idx;
	logic [IDX_W-1:0]        opnd_idx;
	logic [IDX_W-1:0]        cur_idx_s1;
	logic [IDX_W-1:0]        opnd_idx_s1;
	logic [1:0]              k_s1;
	term_t                   term_s1;
	logic [DATA_W-1:0]       cur_rdata;
	logic [DATA_W-1:0]       opnd_rdata;
	logic signed [DATA_W-1:0] a_s1;
	logic signed [DATA_W-1:0] b_s1;
	dot_t                    dot;
	logic                    mac_busy;

	assign in_xfer = item_valid && !item_stall;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item_stall = 1'b1;
		issue      = 1'b0;
		last_issue = 1'b0;
		load_out   = 1'b0;
		flip       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid && (item.op == OP_CONCAT || item.op == OP_XFORM_PT ||
						item.op == OP_XFORM_DIR)) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				issue      = 1'b1;
				last_issue = concat_q ? (cnt_q == 6'd63) : (cnt_q == 6'd11);
				if (last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!term_s1.valid && !mac_busy) begin
					if (concat_q) begin
						flip    = 1'b1;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_DELIVER;
					end
				end
			end
			ST_DELIVER: begin
				if (!out_valid_q || !result_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			concat_q    <= 1'b0;
			point_q     <= 1'b0;
			bank_q      <= 1'b0;
			full_q      <= '0;
			base_id_q   <= 1'b1;
			opv_q       <= '0;
			out_valid_q <= 1'b0;
			term_s1     <= '0;
		end else begin
			term_s1.valid <= issue;
			term_s1.first <= cnt_q[1:0] == 2'd0;
			term_s1.last  <= cnt_q[1:0] == 2'd3;
			term_s1.dest  <= cnt_q[5:2];
			if (in_xfer) begin
				cnt_q    <= '0;
				concat_q <= item.op == OP_CONCAT;
				point_q  <= item.op == OP_XFORM_PT;
				case (item.op)
					OP_WR_COEF: begin
						opv_q[item.coef_index] <= 1'b1;
					end
					OP_IDENTITY: begin
						full_q[bank_q] <= 1'b0;
						base_id_q      <= 1'b1;
					end
					OP_ZERO: begin
						full_q[bank_q] <= 1'b0;
						base_id_q      <= 1'b0;
					end
					default: begin
					end
				endcase
			end else if (issue) begin
				cnt_q <= cnt_q + 6'd1;
			end
			if (flip) begin
				bank_q          <= ~bank_q;
				full_q[~bank_q] <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_valid && !result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			vec_q[0] <= item.in_x;
			vec_q[1] <= item.in_y;
			vec_q[2] <= item.in_z;
			clip_q   <= 1'b0;
		end
		k_s1        <= cnt_q[1:0];
		cur_idx_s1  <= cur_idx;
		opnd_idx_s1 <= opnd_idx;
		if (dot.valid && !concat_q) begin
			res_q[dot.dest[1:0]] <= dot.value;
			clip_q               <= clip_q | dot.sat;
		end
		if (load_out) begin
			out_q.out_x   <= res_q[0];
			out_q.out_y   <= res_q[1];
			out_q.out_z   <= res_q[2];
			out_q.clipped <= clip_q;
		end
	end

	// element (r, c) sits at c*4+r
	assign cur_idx  = {cnt_q[1:0], cnt_q[3:2]};
	assign opnd_idx = {cnt_q[5:4], cnt_q[1:0]};

	mvt_ram #(
		.WIDTH(DATA_W),
		.DEPTH(32)
	) u_cur_ram (
		.clk  (clk),
		.we   (dot.valid && concat_q),
		.waddr({~bank_q, dot.dest}),
		.wdata(dot.value),
		.raddr({bank_q, cur_idx}),
		.rdata(cur_rdata)
	);

	mvt_ram #(
		.WIDTH(DATA_W),
		.DEPTH(16)
	) u_opnd_ram (
		.clk  (clk),
		.we   (in_xfer && item.op == OP_WR_COEF),
		.waddr(item.coef_index),
		.wdata(item.coef_value),
		.raddr(opnd_idx),
		.rdata(opnd_rdata)
	);

	always_comb begin
		if (full_q[bank_q]) begin
			b_s1 = cur_rdata;
		end else if (base_id_q && cur_idx_s1[3:2] == cur_idx_s1[1:0]) begin
			b_s1 = ONE;
		end else begin
			b_s1 = '0;
		end
		if (concat_q) begin
			a_s1 = opv_q[opnd_idx_s1] ? opnd_rdata : '0;
		end else begin
			case (k_s1)
				2'd0:    a_s1 = vec_q[0];
				2'd1:    a_s1 = vec_q[1];
				2'd2:    a_s1 = vec_q[2];
				default: a_s1 = point_q ? ONE : '0;
			endcase
		end
	end

	mvt_mac #(
		.FRAC_BITS(FRAC_BITS)
	) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.term  (term_s1),
		.a     (a_s1),
		.b     (b_s1),
		.dot   (dot),
		.busy  (mac_busy)
	);

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

`default_nettype wire

>>> hdl/mvt_checker.sv
// ---------------------------------------------------------------------------
// mvt_checker
// Port-level checks for the matrix vertex transform block.
// ---------------------------------------------------------------------------
`default_nettype none

module mvt_checker
	import mvt_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    item_valid,
	input wire logic    item_stall,
	input wire item_t   item,
	input wire logic    result_valid,
	input wire logic    result_stall,
	input wire result_t result
);

	logic in_xfer;

	assign in_xfer = item_valid && !item_stall;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_long_op_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (item.op == OP_CONCAT || item.op == OP_XFORM_PT ||
			item.op == OP_XFORM_DIR) |=> item_stall)
		else $error("multi-cycle op did not hold off the next transfer");

	a_short_op_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (item.op == OP_WR_COEF || item.op == OP_IDENTITY ||
			item.op == OP_ZERO) |=> !item_stall)
		else $error("single-cycle op stalled the item channel");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result appeared without a transform in flight");

endmodule

bind matrix_vertex_transform mvt_checker u_mvt_checker (.*);

`default_nettype wire
